@@ rtl/core/text_console_writer_assert.svh @@
// Assertion macros for the console writer controller (ctw_ctrl).
// Each macro expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define CTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ctw_pkg.sv @@
package ctw_pkg;

  // Default screen geometry
  localparam int unsigned ScreenRows = 25;
  localparam int unsigned ScreenCols = 80;

  // Field widths
  localparam int unsigned ActW  = 2;
  localparam int unsigned CharW = 8;
  localparam int unsigned AttrW = 8;
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 7;

  // Character codes and blank cell
  localparam logic [CharW-1:0] CrCode    = 8'd13;
  localparam logic [CharW-1:0] LfCode    = 8'd10;
  localparam logic [CharW-1:0] BlankChar = 8'h20;
  localparam logic [AttrW-1:0] ResetAttr = 8'h0F;

  typedef enum logic [ActW-1:0] {
    ActPut   = 2'd0,
    ActClear = 2'd1,
    ActRead  = 2'd2
  } action_e;

  // One result word
  typedef struct packed {
    logic [ColW-1:0]  cursor_col;
    logic [RowW-1:0]  cursor_row;
    logic [AttrW-1:0] cell_attribute;
    logic [CharW-1:0] cell_char;
  } result_t;

endpackage

@@ rtl/core/ctw_store.sv @@
module ctw_store #(
  parameter int unsigned CELL_COUNT = ctw_pkg::ScreenRows * ctw_pkg::ScreenCols
) (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic                                         we_i,
  input  logic [$clog2(CELL_COUNT)-1:0]                addr_i,
  input  logic [ctw_pkg::AttrW+ctw_pkg::CharW-1:0]     wdata_i,
  output logic [ctw_pkg::AttrW+ctw_pkg::CharW-1:0]     rdata_o
);
  import ctw_pkg::*;

  localparam int unsigned CellW = AttrW + CharW;

  logic [CellW-1:0] mem_q [CELL_COUNT];
  logic [CellW-1:0] rdata_q;

  // Write one cell
  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read one cell; hold data until the next read
  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ctw_ctrl.sv @@
`include "text_console_writer_assert.svh"

module ctw_ctrl #(
  parameter int unsigned SCREEN_ROWS = ctw_pkg::ScreenRows,
  parameter int unsigned SCREEN_COLS = ctw_pkg::ScreenCols
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // Item side
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [ctw_pkg::ActW-1:0]                      action_i,
  input  logic [ctw_pkg::CharW-1:0]                     char_code_i,
  input  logic [ctw_pkg::RowW-1:0]                      read_row_i,
  input  logic [ctw_pkg::ColW-1:0]                      read_col_i,
  // Attribute register write
  input  logic                                          cfg_we_i,
  input  logic [ctw_pkg::AttrW-1:0]                     cfg_wdata_i,
  // Result side
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output ctw_pkg::result_t                              res_o,
  // Cell store
  output logic                                          mem_en_o,
  output logic                                          mem_we_o,
  output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0]    mem_addr_o,
  output logic [ctw_pkg::AttrW+ctw_pkg::CharW-1:0]      mem_wdata_o,
  input  logic [ctw_pkg::AttrW+ctw_pkg::CharW-1:0]      mem_rdata_i
);
  import ctw_pkg::*;

  localparam int unsigned CellCount = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned RowIdxW   = $clog2(SCREEN_ROWS);
  localparam int unsigned ColIdxW   = $clog2(SCREEN_COLS);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StInit  = 4'b0010,
    StBlank = 4'b0100,
    StResp  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [RowIdxW-1:0]   row_q, row_d;
  logic [ColIdxW-1:0]   col_q, col_d;
  logic [RowIdxW-1:0]   top_q, top_d;
  logic [AddrW-1:0]     sweep_q, sweep_d;
  logic [AddrW-1:0]     last_q, last_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [AttrW-1:0]     attr_q;

  logic [RowIdxW-1:0]   cur_phys;
  logic [RowIdxW-1:0]   rd_phys;
  logic [AddrW-1:0]     cur_addr;
  logic [AddrW-1:0]     rd_addr;
  logic [AddrW-1:0]     top_base;
  logic [RowIdxW-1:0]   top_next;
  logic                 rd_in_range;
  logic                 col_last;
  logic                 row_last;
  logic                 newline;
  logic                 accept;

  // Map a screen row onto a store row through the scroll offset
  function automatic logic [RowIdxW-1:0] wrap_row(input logic [RowIdxW-1:0] a,
                                                  input logic [RowIdxW-1:0] b);
    logic [RowIdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (RowIdxW+1)'(SCREEN_ROWS)) begin
      sum = sum - (RowIdxW+1)'(SCREEN_ROWS);
    end
    return sum[RowIdxW-1:0];
  endfunction

  // Address and cursor decode
  assign cur_phys    = wrap_row(top_q, row_q);
  assign rd_phys     = wrap_row(top_q, RowIdxW'(read_row_i));
  assign cur_addr    = AddrW'(cur_phys) * AddrW'(SCREEN_COLS) + AddrW'(col_q);
  assign rd_addr     = AddrW'(rd_phys) * AddrW'(SCREEN_COLS) + AddrW'(ColIdxW'(read_col_i));
  assign top_base    = AddrW'(top_q) * AddrW'(SCREEN_COLS);
  assign top_next    = (top_q == RowIdxW'(SCREEN_ROWS - 1)) ? '0 : top_q + 1'b1;
  assign rd_in_range = (32'(read_row_i) < 32'(SCREEN_ROWS)) &&
                       (32'(read_col_i) < 32'(SCREEN_COLS));
  assign col_last    = (col_q == ColIdxW'(SCREEN_COLS - 1));
  assign row_last    = (row_q == RowIdxW'(SCREEN_ROWS - 1));
  assign newline     = (char_code_i == LfCode) || col_last;
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    sweep_d     = sweep_q;
    last_d      = last_q;
    rd_ok_d     = rd_ok_q;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = cur_addr;
    mem_wdata_o = {attr_q, char_code_i};
    res_valid_o = 1'b0;
    case (state_q)
      StInit: begin
        // Blank every cell after reset
        mem_en_o    = 1'b1;
        mem_we_o    = 1'b1;
        mem_addr_o  = sweep_q;
        mem_wdata_o = {ResetAttr, BlankChar};
        if (sweep_q == last_q) begin
          state_d = StIdle;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      StIdle: begin
        if (accept) begin
          rd_ok_d = 1'b0;
          state_d = StResp;
          case (action_i)
            ActPut: begin
              if (char_code_i == CrCode) begin
                col_d = '0;
              end else begin
                if (char_code_i != LfCode) begin
                  mem_en_o = 1'b1;
                  mem_we_o = 1'b1;
                end
                if (!newline) begin
                  col_d = col_q + 1'b1;
                end else begin
                  col_d = '0;
                  if (!row_last) begin
                    row_d = row_q + 1'b1;
                  end else begin
                    // Scroll: advance the offset, blank the old top row
                    top_d   = top_next;
                    sweep_d = top_base;
                    last_d  = top_base + AddrW'(SCREEN_COLS - 1);
                    state_d = StBlank;
                  end
                end
              end
            end
            ActClear: begin
              row_d   = '0;
              col_d   = '0;
              top_d   = '0;
              sweep_d = '0;
              last_d  = AddrW'(CellCount - 1);
              state_d = StBlank;
            end
            ActRead: begin
              if (rd_in_range) begin
                mem_en_o   = 1'b1;
                mem_addr_o = rd_addr;
                rd_ok_d    = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StBlank: begin
        mem_en_o    = 1'b1;
        mem_we_o    = 1'b1;
        mem_addr_o  = sweep_q;
        mem_wdata_o = {attr_q, BlankChar};
        if (sweep_q == last_q) begin
          state_d = StResp;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      StResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result word
  always_comb begin
    res_o.cell_char      = rd_ok_q ? mem_rdata_i[CharW-1:0] : '0;
    res_o.cell_attribute = rd_ok_q ? mem_rdata_i[CharW+AttrW-1:CharW] : '0;
    res_o.cursor_row     = RowW'(row_q);
    res_o.cursor_col     = ColW'(col_q);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      sweep_q <= '0;
      last_q  <= AddrW'(CellCount - 1);
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      sweep_q <= sweep_d;
      last_q  <= last_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // Attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ResetAttr;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  `CTW_ASSERT_NOW(a_row_in_screen, 1'b1, 32'(row_q) < 32'(SCREEN_ROWS), "cursor row out of screen")
  `CTW_ASSERT_NOW(a_col_in_screen, 1'b1, 32'(col_q) < 32'(SCREEN_COLS), "cursor column out of screen")
  `CTW_ASSERT_NOW(a_no_write_in_resp, state_q == StResp, !mem_we_o, "store written while result pending")
  `CTW_ASSERT_NEXT(a_read_to_resp, accept && (action_i == ActRead) && rd_in_range, (state_q == StResp) && rd_ok_q, "read did not reach result stage")

endmodule

@@ rtl/core/text_console_writer.sv @@
// Channel  | Dir | Fields (low bit first)
// s_axis   | in  | tuser: action[1:0]; tdata: char_code[7:0], read_row[12:8], read_col[19:13]
// m_axis   | out | tdata: cell_char[7:0], cell_attribute[15:8], cursor_row[20:16],
//          |     |        cursor_col[27:21]
// cfg      | in  | cfg_we_i / cfg_wdata_i: text attribute byte
// Put and read go from accept through the store access (single port, registered
// read) to the result state, which hands the result to the output register.
// A put that scrolls first blanks one row; the store keeps a row offset, so no
// rows are copied. Clear first blanks every cell. After reset a blanking pass
// over every cell runs before the first item is accepted. A result waits in the
// output register while the next item is taken; the sequencer stalls only when
// that register is still full.
module text_console_writer #(
  parameter int unsigned SCREEN_ROWS = ctw_pkg::ScreenRows,
  parameter int unsigned SCREEN_COLS = ctw_pkg::ScreenCols
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // char_code, read_row, read_col
  input  logic [ctw_pkg::ActW-1:0]   s_axis_tuser,  // action
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // cell_char, cell_attribute,
                                                    // cursor_row, cursor_col
  input  logic                       cfg_we_i,
  input  logic [ctw_pkg::AttrW-1:0]  cfg_wdata_i
);
  import ctw_pkg::*;

  localparam int unsigned CellCount = SCREEN_ROWS * SCREEN_COLS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned CellW     = AttrW + CharW;

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             mem_en;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [CellW-1:0] mem_wdata;
  logic [CellW-1:0] mem_rdata;
  logic             out_valid_q;
  result_t          out_q;

  ctw_ctrl #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .char_code_i (s_axis_tdata[7:0]),
    .read_row_i  (s_axis_tdata[12:8]),
    .read_col_i  (s_axis_tdata[19:13]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  ctw_store #(
    .CELL_COUNT (CellCount)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: take a result when empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import ctw_pkg::*;

  localparam logic [ActW-1:0] ActUnused = 2'd3;
  localparam int DirCount      = 24;
  localparam int PhaseCount    = 5;
  localparam int PhaseItems    = 205;
  localparam int HoldCycles    = 600;
  localparam int DrainCycles   = 100;
  localparam int WatchdogLimit = 20000;

  // One directed word with its hand-written result where it is obvious
  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [CharW-1:0] ch;
    logic [RowW-1:0]  rr;
    logic [ColW-1:0]  rc;
    logic             typed;
    logic [CharW-1:0] e_char;
    logic [AttrW-1:0] e_attr;
    logic [RowW-1:0]  e_row;
    logic [ColW-1:0]  e_col;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    '{ActRead,   8'h00,  5'd0,  7'd0,   1'b1, BlankChar, ResetAttr, 5'd0, 7'd0},
    '{ActRead,   8'hFF,  5'd24, 7'd79,  1'b1, BlankChar, ResetAttr, 5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd25, 7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd0,  7'd80,  1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd31, 7'd127, 1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActUnused, 8'hFF,  5'd31, 7'd127, 1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActPut,    8'h41,  5'd31, 7'd127, 1'b1, 8'h00,     8'h00,     5'd0, 7'd1},
    '{ActPut,    8'h00,  5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd2},
    '{ActPut,    8'hFF,  5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd3},
    '{ActRead,   8'h00,  5'd0,  7'd0,   1'b1, 8'h41,     ResetAttr, 5'd0, 7'd3},
    '{ActRead,   8'h00,  5'd0,  7'd1,   1'b1, 8'h00,     ResetAttr, 5'd0, 7'd3},
    '{ActRead,   8'h00,  5'd0,  7'd2,   1'b1, 8'hFF,     ResetAttr, 5'd0, 7'd3},
    '{ActPut,    CrCode, 5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActPut,    8'h42,  5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd1},
    '{ActRead,   8'h00,  5'd0,  7'd0,   1'b1, 8'h42,     ResetAttr, 5'd0, 7'd1},
    '{ActPut,    LfCode, 5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd1, 7'd0},
    '{ActPut,    LfCode, 5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd2, 7'd0},
    '{ActPut,    8'h7A,  5'd0,  7'd0,   1'b0, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd2,  7'd0,   1'b0, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd1,  7'd5,   1'b1, BlankChar, ResetAttr, 5'd2, 7'd1},
    '{ActClear,  8'h55,  5'd3,  7'd3,   1'b1, 8'h00,     8'h00,     5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd0,  7'd0,   1'b1, BlankChar, ResetAttr, 5'd0, 7'd0},
    '{ActRead,   8'h00,  5'd2,  7'd0,   1'b1, BlankChar, ResetAttr, 5'd0, 7'd0},
    '{ActPut,    CrCode, 5'd0,  7'd0,   1'b1, 8'h00,     8'h00,     5'd0, 7'd0}
  };

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata   = '0;
  logic [ActW-1:0]      s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [31:0]          m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [AttrW-1:0]     cfg_wdata = '0;

  // Shadow copy of the screen, cursor and attribute
  logic [15:0]  shadow_screen [ScreenRows][ScreenCols];
  int unsigned  shadow_row;
  int unsigned  shadow_col;
  logic [7:0]   shadow_attr;

  result_t      awaited_reports [$];
  int           fail_count  = 0;
  int           items_sent  = 0;
  bit           gaps_on     = 1'b1;
  bit           stalls_on   = 1'b1;
  bit           hold_req    = 1'b0;
  int           quiet_cycles = 0;

  text_console_writer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Blank every cell with the current attribute and home the cursor
  function automatic void shadow_clear();
    for (int r = 0; r < ScreenRows; r++) begin
      for (int c = 0; c < ScreenCols; c++) begin
        shadow_screen[r][c] = {shadow_attr, BlankChar};
      end
    end
    shadow_row = 0;
    shadow_col = 0;
  endfunction

  // Advance the row; past the bottom line shift everything up one row
  function automatic void shadow_next_row();
    if (shadow_row + 1 < ScreenRows) begin
      shadow_row++;
    end else begin
      for (int r = 0; r < ScreenRows - 1; r++) begin
        for (int c = 0; c < ScreenCols; c++) begin
          shadow_screen[r][c] = shadow_screen[r + 1][c];
        end
      end
      for (int c = 0; c < ScreenCols; c++) begin
        shadow_screen[ScreenRows - 1][c] = {shadow_attr, BlankChar};
      end
    end
  endfunction

  // Apply one word to the shadow console and return the cell and cursor report
  function automatic result_t console_update(logic [ActW-1:0] act, logic [CharW-1:0] ch,
                                             logic [RowW-1:0] rr, logic [ColW-1:0] rc);
    result_t rep;
    rep = '0;
    case (act)
      ActPut: begin
        if (ch == CrCode) begin
          shadow_col = 0;
        end else if (ch == LfCode) begin
          shadow_col = 0;
          shadow_next_row();
        end else begin
          shadow_screen[shadow_row][shadow_col] = {shadow_attr, ch};
          shadow_col++;
          if (shadow_col >= ScreenCols) begin
            shadow_col = 0;
            shadow_next_row();
          end
        end
      end
      ActClear: shadow_clear();
      ActRead: begin
        if (rr < ScreenRows && rc < ScreenCols) begin
          {rep.cell_attribute, rep.cell_char} = shadow_screen[rr][rc];
        end
      end
      default: ;
    endcase
    rep.cursor_row = shadow_row[RowW-1:0];
    rep.cursor_col = shadow_col[ColW-1:0];
    return rep;
  endfunction

  // Offer one word, wait for it to be taken, then record its report
  task automatic send_word(logic [ActW-1:0] act, logic [CharW-1:0] ch, logic [RowW-1:0] rr,
                           logic [ColW-1:0] rc, bit typed, result_t want);
    result_t predicted;
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, rc, rr, ch};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = console_update(act, ch, rr, rc);
    awaited_reports.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Read a cell: mostly on screen, often on the cursor row, some corners and misses
  task automatic send_random_read();
    int pick;
    logic [RowW-1:0] rr;
    logic [ColW-1:0] rc;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      rr = RowW'($urandom_range(0, ScreenRows - 1));
      rc = ColW'($urandom_range(0, ScreenCols - 1));
    end else if (pick < 7) begin
      rr = shadow_row[RowW-1:0];
      rc = ColW'($urandom_range(0, ScreenCols - 1));
    end else if (pick == 7) begin
      rr = $urandom_range(0, 1) ? RowW'(ScreenRows - 1) : '0;
      rc = $urandom_range(0, 1) ? ColW'(ScreenCols - 1) : '0;
    end else if ($urandom_range(0, 1)) begin
      rr = RowW'($urandom_range(ScreenRows, 31));
      rc = ColW'($urandom_range(0, 127));
    end else begin
      rr = RowW'($urandom_range(0, 31));
      rc = ColW'($urandom_range(ScreenCols, 127));
    end
    send_word(ActRead, CharW'($urandom_range(0, 255)), rr, rc, 1'b0, '0);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= !(stalls_on && $urandom_range(0, 99) < 7);
      end
    end
  end

  task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each returned word against the oldest awaited report
  always @(posedge clk) begin : check_reports
    result_t got;
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (awaited_reports.size() == 0) begin
        $display("%0t ERROR unexpected word expected none actual %0h", $time, m_tdata);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        report_field("cell_char", want.cell_char, got.cell_char);
        report_field("cell_attribute", want.cell_attribute, got.cell_attribute);
        report_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
        report_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
      end
    end
  end

  // Drop the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("text_console_writer: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int ending;
    shadow_attr = ResetAttr;
    shadow_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset attribute
    for (int i = 0; i < DirCount; i++) begin
      send_word(DirRows[i].act, DirRows[i].ch, DirRows[i].rr, DirRows[i].rc, DirRows[i].typed,
                {DirRows[i].e_col, DirRows[i].e_row, DirRows[i].e_attr, DirRows[i].e_char});
    end

    for (int p = 0; p < PhaseCount; p++) begin
      // Drain, then change the attribute while the block is idle
      s_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clk);
      @(negedge clk);
      cfg_we      <= 1'b1;
      shadow_attr  = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      cfg_wdata   <= shadow_attr;
      @(negedge clk);
      cfg_we      <= 1'b0;
      gaps_on   = (p != 1);
      stalls_on = (p != 1);
      if (p == 2) hold_req = 1'b1;

      while (items_sent < DirCount + (p + 1) * PhaseItems) begin
        kind = $urandom_range(0, 99);
        if (kind < 2) begin
          send_word(ActClear, CharW'($urandom_range(0, 255)), RowW'($urandom_range(0, 31)),
                    ColW'($urandom_range(0, 127)), 1'b0, '0);
        end else if (kind < 7) begin
          send_word(ActUnused, CharW'($urandom_range(0, 255)), RowW'($urandom_range(0, 31)),
                    ColW'($urandom_range(0, 127)), 1'b0, '0);
        end else if (kind < 19) begin
          // Run of empty lines, quick way to the bottom and into scrolling
          repeat ($urandom_range(1, 6)) begin
            send_word(ActPut, LfCode, RowW'($urandom_range(0, 31)),
                      ColW'($urandom_range(0, 127)), 1'b0, '0);
          end
        end else if (kind < 27) begin
          repeat ($urandom_range(1, 4)) send_random_read();
        end else begin
          // One line of text: mostly short, some long enough to wrap
          len = ($urandom_range(0, 9) < 2) ? $urandom_range(60, 130) : $urandom_range(0, 12);
          for (int c = 0; c < len; c++) begin
            if ($urandom_range(0, 99) < 15) begin
              send_random_read();
            end else begin
              send_word(ActPut, CharW'($urandom_range(0, 255)), RowW'($urandom_range(0, 31)),
                        ColW'($urandom_range(0, 127)), 1'b0, '0);
            end
          end
          ending = $urandom_range(0, 9);
          if (ending >= 7 && ending <= 8) begin
            send_word(ActPut, CrCode, RowW'($urandom_range(0, 31)),
                      ColW'($urandom_range(0, 127)), 1'b0, '0);
          end
          if (ending <= 7) begin
            send_word(ActPut, LfCode, RowW'($urandom_range(0, 31)),
                      ColW'($urandom_range(0, 127)), 1'b0, '0);
          end
        end
      end
    end

    // Wait out the last reports, then a little longer for strays
    s_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ctw_pkg.sv
rtl/core/ctw_store.sv
rtl/core/ctw_ctrl.sv
rtl/core/text_console_writer.sv
tb/tb.sv
